@@ design/obb_pkg.sv @@
`default_nettype none
package obb_pkg;

  localparam int unsigned ComponentBitsDef = 16;
  localparam int unsigned SineEntriesDef   = 256;

  localparam int unsigned FieldBits = 48;
  localparam int unsigned AngleBits = 16;
  localparam int unsigned TrigBits  = 16;  // Q1.14 sine / cosine
  localparam int unsigned BasisBits = 18;  // Q1.14 basis entries, with headroom
  localparam int unsigned AxisBits  = 32;  // Q28 axis components
  localparam int unsigned FracBits  = 14;
  localparam int unsigned NumAxes   = 15;

  localparam int unsigned ThrBits  = 30;
  localparam int unsigned ThrShift = 28;
  localparam logic [ThrBits-1:0] ThrReset = 30'd268;

  localparam int unsigned QueueDepth = 8;

  // Q1.14 sine of a 16-bit binary angle, polynomial per quadrant
  function automatic logic signed [TrigBits-1:0] sine_u(input logic [AngleBits-1:0] u);
    logic [1:0]  q;
    logic [31:0] z;
    logic [31:0] z2;
    logic [31:0] i1;
    logic [31:0] i2;
    logic [31:0] s;
    q  = u[AngleBits-1 -: 2];
    z  = 32'(u[FracBits-1:0]);
    if (q[0]) begin
      z = 32'd16384 - z;
    end
    z2 = (z * z) >> FracBits;
    i1 = 32'd10512 - ((z2 * 32'd1160) >> FracBits);
    i2 = 32'd25736 - ((z2 * i1) >> FracBits);
    s  = (z * i2) >> FracBits;
    if (s > 32'd16384) begin
      s = 32'd16384;
    end
    return q[1] ? TrigBits'(32'd0 - s) : TrigBits'(s);
  endfunction

  // round half up, drop 14 fraction bits
  function automatic logic signed [63:0] rnd14(input logic signed [63:0] p);
    return (p + 64'sd8192) >>> FracBits;
  endfunction

endpackage
`default_nettype wire

@@ design/obb_basis.sv @@
`default_nettype none
module obb_basis #(
  parameter int unsigned SineEntries = obb_pkg::SineEntriesDef
) (
  input  logic                                      clk_i,
  input  logic [obb_pkg::FieldBits-1:0]             angles_i,
  output logic [9*obb_pkg::BasisBits-1:0]           basis_o
);

  localparam int unsigned TB      = obb_pkg::TrigBits;
  localparam int unsigned BW      = obb_pkg::BasisBits;
  localparam int unsigned AB      = obb_pkg::AngleBits;
  localparam int unsigned IdxBits = (SineEntries > 1) ? $clog2(SineEntries) : 1;
  localparam int unsigned PB      = 2 * TB + 2;

  logic signed [TB-1:0] sin_tab [SineEntries];
  logic signed [TB-1:0] cos_tab [SineEntries];

  for (genvar i = 0; i < SineEntries; i++) begin : g_tab
    localparam int unsigned TabAngle = (i * 65536) / SineEntries;
    assign sin_tab[i] = obb_pkg::sine_u(AB'(TabAngle));
    assign cos_tab[i] = obb_pkg::sine_u(AB'(TabAngle + 16384));
  end

  // stage 1: table lookups, k = 0 pitch (x), 1 yaw (y), 2 roll (z)
  logic [IdxBits-1:0]   idx [3];
  logic signed [TB-1:0] s_q [3];
  logic signed [TB-1:0] c_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      idx[k] = IdxBits'((32'(angles_i[k*AB +: AB]) * 32'(SineEntries)) >> AB);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s_q[k] <= sin_tab[idx[k]];
      c_q[k] <= cos_tab[idx[k]];
    end
  end

  // stage 2
  logic signed [BW-1:0] t_q, w_q, c01_q, c11_q, c20_q, c21_q, c22_q;
  logic signed [BW-1:0] sz_q, cz_q;
  logic signed [PB-1:0] cycz_q, sycz_q, cysz_q, sysz_q;

  always_ff @(posedge clk_i) begin
    t_q    <= BW'(obb_pkg::rnd14(64'(PB'(s_q[1]) * PB'(s_q[0]))));
    w_q    <= BW'(obb_pkg::rnd14(64'(PB'(c_q[1]) * PB'(s_q[0]))));
    c01_q  <= BW'(obb_pkg::rnd14(64'(PB'(c_q[0]) * PB'(s_q[2]))));
    c11_q  <= BW'(obb_pkg::rnd14(64'(PB'(c_q[0]) * PB'(c_q[2]))));
    c20_q  <= BW'(obb_pkg::rnd14(64'(PB'(s_q[1]) * PB'(c_q[0]))));
    c22_q  <= BW'(obb_pkg::rnd14(64'(PB'(c_q[1]) * PB'(c_q[0]))));
    c21_q  <= BW'(0) - BW'(s_q[0]);
    sz_q   <= BW'(s_q[2]);
    cz_q   <= BW'(c_q[2]);
    cycz_q <= PB'(c_q[1]) * PB'(c_q[2]);
    sycz_q <= PB'(s_q[1]) * PB'(c_q[2]);
    cysz_q <= PB'(c_q[1]) * PB'(s_q[2]);
    sysz_q <= PB'(s_q[1]) * PB'(s_q[2]);
  end

  // stage 3
  logic signed [BW-1:0] col [3][3];

  always_comb begin
    col[0][0] = BW'(obb_pkg::rnd14(64'(cycz_q + PB'(t_q) * PB'(sz_q))));
    col[0][1] = c01_q;
    col[0][2] = BW'(obb_pkg::rnd14(64'(PB'(w_q) * PB'(sz_q) - sycz_q)));
    col[1][0] = BW'(obb_pkg::rnd14(64'(PB'(t_q) * PB'(cz_q) - cysz_q)));
    col[1][1] = c11_q;
    col[1][2] = BW'(obb_pkg::rnd14(64'(sysz_q + PB'(w_q) * PB'(cz_q))));
    col[2][0] = c20_q;
    col[2][1] = c21_q;
    col[2][2] = c22_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        basis_o[(i*3+k)*BW +: BW] <= col[i][k];
      end
    end
  end

endmodule
`default_nettype wire

@@ design/obb_front.sv @@
`default_nettype none
module obb_front #(
  parameter int unsigned CompBits    = obb_pkg::ComponentBitsDef,
  parameter int unsigned SineEntries = obb_pkg::SineEntriesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [obb_pkg::FieldBits-1:0]     first_position_i,
  input  logic [obb_pkg::FieldBits-1:0]     first_offset_i,
  input  logic [obb_pkg::FieldBits-1:0]     first_angles_i,
  input  logic [obb_pkg::FieldBits-1:0]     first_half_size_i,
  input  logic [obb_pkg::FieldBits-1:0]     second_position_i,
  input  logic [obb_pkg::FieldBits-1:0]     second_offset_i,
  input  logic [obb_pkg::FieldBits-1:0]     second_angles_i,
  input  logic [obb_pkg::FieldBits-1:0]     second_half_size_i,
  output logic                              valid_o,
  output logic [9*obb_pkg::BasisBits-1:0]   basis_a_o,
  output logic [9*obb_pkg::BasisBits-1:0]   basis_b_o,
  output logic [3*(CompBits+2)-1:0]         diff_o,
  output logic [3*CompBits-1:0]             half_a_o,
  output logic [3*CompBits-1:0]             half_b_o
);

  localparam int unsigned DW = CompBits + 2;
  localparam int unsigned PadBits =
      (3 * CompBits > obb_pkg::FieldBits) ? 3 * CompBits : obb_pkg::FieldBits;
  localparam int unsigned Lat = 3;

  logic [PadBits-1:0] pa, oa, pb, ob, ha, hb;
  assign pa = PadBits'(first_position_i);
  assign oa = PadBits'(first_offset_i);
  assign pb = PadBits'(second_position_i);
  assign ob = PadBits'(second_offset_i);
  assign ha = PadBits'(first_half_size_i);
  assign hb = PadBits'(second_half_size_i);

  obb_basis #(.SineEntries(SineEntries)) u_basis_a (
    .clk_i   (clk_i),
    .angles_i(first_angles_i),
    .basis_o (basis_a_o)
  );

  obb_basis #(.SineEntries(SineEntries)) u_basis_b (
    .clk_i   (clk_i),
    .angles_i(second_angles_i),
    .basis_o (basis_b_o)
  );

  // centre difference: (pos + off) of box two minus that of box one
  logic [3*DW-1:0] diff_d;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_d[k*DW +: DW] = DW'($signed(pb[k*CompBits +: CompBits]))
                         + DW'($signed(ob[k*CompBits +: CompBits]))
                         - DW'($signed(pa[k*CompBits +: CompBits]))
                         - DW'($signed(oa[k*CompBits +: CompBits]));
    end
  end

  logic [Lat-1:0]        vld_q;
  logic [3*DW-1:0]       diff_q  [Lat];
  logic [3*CompBits-1:0] hfa_q   [Lat];
  logic [3*CompBits-1:0] hfb_q   [Lat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q[0] <= diff_d;
    hfa_q[0]  <= ha[3*CompBits-1:0];
    hfb_q[0]  <= hb[3*CompBits-1:0];
    for (int s = 1; s < Lat; s++) begin
      diff_q[s] <= diff_q[s-1];
      hfa_q[s]  <= hfa_q[s-1];
      hfb_q[s]  <= hfb_q[s-1];
    end
  end

  assign valid_o  = vld_q[Lat-1];
  assign diff_o   = diff_q[Lat-1];
  assign half_a_o = hfa_q[Lat-1];
  assign half_b_o = hfb_q[Lat-1];

endmodule
`default_nettype wire

@@ design/obb_queue.sv @@
`default_nettype none
module obb_queue #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = obb_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wptr_q, rptr_q;
  logic [CntBits-1:0] cnt_q;

  function automatic logic [PtrBits-1:0] incr(input logic [PtrBits-1:0] p);
    return (p == PtrBits'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= incr(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= incr(rptr_q);
      end
      cnt_q <= cnt_q + CntBits'(push_i) - CntBits'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop_i && cnt_q == CntBits'(Depth)))
    else $error("request written into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("request taken from an empty queue");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(Depth))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

@@ design/obb_back.sv @@
`default_nettype none
module obb_back #(
  parameter int unsigned CompBits = obb_pkg::ComponentBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [obb_pkg::ThrBits-1:0]       thr_i,
  input  logic                              q_empty_i,
  input  logic [9*obb_pkg::BasisBits-1:0]   basis_a_i,
  input  logic [9*obb_pkg::BasisBits-1:0]   basis_b_i,
  input  logic [3*(CompBits+2)-1:0]         diff_i,
  input  logic [3*CompBits-1:0]             half_a_i,
  input  logic [3*CompBits-1:0]             half_b_i,
  output logic                              q_pop_o,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic                              overlap_o
);

  localparam int unsigned BW   = obb_pkg::BasisBits;
  localparam int unsigned LW   = obb_pkg::AxisBits;
  localparam int unsigned NA   = obb_pkg::NumAxes;
  localparam int unsigned DW   = CompBits + 2;
  localparam int unsigned XW   = 2 * BW + 1;
  localparam int unsigned DotW = BW + LW + 2;
  localparam int unsigned DprW = DW + LW + 2;
  localparam int unsigned RdW  = DotW - obb_pkg::FracBits;
  localparam int unsigned MW   = RdW + CompBits;
  localparam int unsigned RW   = MW + 3;

  logic en;
  logic out_vld_q;
  assign en      = !out_vld_q || pop_i;
  assign q_pop_o = en && !q_empty_i;

  // stage 1: candidate axes
  logic signed [BW-1:0] ca [3][3];
  logic signed [BW-1:0] cb [3][3];
  logic signed [LW-1:0] ax_d [NA][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        ca[i][k] = $signed(basis_a_i[(i*3+k)*BW +: BW]);
        cb[i][k] = $signed(basis_b_i[(i*3+k)*BW +: BW]);
        ax_d[i][k]   = LW'(ca[i][k]) <<< obb_pkg::FracBits;
        ax_d[3+i][k] = LW'(cb[i][k]) <<< obb_pkg::FracBits;
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ax_d[6+i*3+j][0] = LW'(XW'(ca[i][1]) * XW'(cb[j][2]) - XW'(ca[i][2]) * XW'(cb[j][1]));
        ax_d[6+i*3+j][1] = LW'(XW'(ca[i][2]) * XW'(cb[j][0]) - XW'(ca[i][0]) * XW'(cb[j][2]));
        ax_d[6+i*3+j][2] = LW'(XW'(ca[i][0]) * XW'(cb[j][1]) - XW'(ca[i][1]) * XW'(cb[j][0]));
      end
    end
  end

  logic                  v1_q;
  logic signed [LW-1:0]  ax1_q [NA][3];
  logic signed [BW-1:0]  col1_q [6][3];
  logic signed [DW-1:0]  df1_q [3];
  logic [3*CompBits-1:0] ha1_q, hb1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q <= ax_d;
      for (int i = 0; i < 3; i++) begin
        col1_q[i]   <= ca[i];
        col1_q[3+i] <= cb[i];
        df1_q[i]    <= $signed(diff_i[i*DW +: DW]);
      end
      ha1_q <= half_a_i;
      hb1_q <= half_b_i;
    end
  end

  // stage 2: squared lengths, centre projection, column projections
  logic [63:0]            len2_d [NA];
  logic signed [DprW-1:0] dp_d   [NA];
  logic signed [DotW-1:0] dot_d  [NA][6];

  always_comb begin
    for (int n = 0; n < NA; n++) begin
      len2_d[n] = '0;
      dp_d[n]   = '0;
      for (int k = 0; k < 3; k++) begin
        len2_d[n] = len2_d[n] + 64'(64'(ax1_q[n][k]) * 64'(ax1_q[n][k]));
        dp_d[n]   = dp_d[n] + DprW'(df1_q[k]) * DprW'(ax1_q[n][k]);
      end
      for (int c = 0; c < 6; c++) begin
        dot_d[n][c] = '0;
        for (int k = 0; k < 3; k++) begin
          dot_d[n][c] = dot_d[n][c] + DotW'(col1_q[c][k]) * DotW'(ax1_q[n][k]);
        end
      end
    end
  end

  logic                   v2_q;
  logic [63:0]            len2_q [NA];
  logic signed [DprW-1:0] dp_q   [NA];
  logic signed [DotW-1:0] dot_q  [NA][6];
  logic [3*CompBits-1:0]  ha2_q, hb2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      len2_q <= len2_d;
      dp_q   <= dp_d;
      dot_q  <= dot_d;
      ha2_q  <= ha1_q;
      hb2_q  <= hb1_q;
    end
  end

  // stage 3: skip test, magnitudes, radius terms
  logic [63:0]          limit;
  logic [NA-1:0]        skip_d;
  logic [DprW-1:0]      ad_d [NA];
  logic [MW-1:0]        m_d  [NA][6];
  logic signed [RdW-1:0] rd;
  logic [RdW-1:0]       mag;
  logic [CompBits-1:0]  hv;

  assign limit = 64'(thr_i) << obb_pkg::ThrShift;

  always_comb begin
    rd  = '0;
    mag = '0;
    hv  = '0;
    for (int n = 0; n < NA; n++) begin
      skip_d[n] = len2_q[n] < limit;
      ad_d[n]   = dp_q[n][DprW-1] ? DprW'(-dp_q[n]) : DprW'(dp_q[n]);
      for (int c = 0; c < 6; c++) begin
        rd  = RdW'(obb_pkg::rnd14(64'(dot_q[n][c])));
        mag = rd[RdW-1] ? RdW'(-rd) : RdW'(rd);
        hv  = (c < 3) ? ha2_q[(c%3)*CompBits +: CompBits] : hb2_q[(c%3)*CompBits +: CompBits];
        m_d[n][c] = MW'(mag) * MW'(hv);
      end
    end
  end

  logic            v3_q;
  logic [NA-1:0]   skip_q;
  logic [DprW-1:0] ad_q [NA];
  logic [MW-1:0]   m_q  [NA][6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      skip_q <= skip_d;
      ad_q   <= ad_d;
      m_q    <= m_d;
    end
  end

  // stage 4: radius sum and separation test per axis
  logic [RW-1:0] r_d [NA];
  logic [NA-1:0] sep_d;

  always_comb begin
    for (int n = 0; n < NA; n++) begin
      r_d[n] = '0;
      for (int c = 0; c < 6; c++) begin
        r_d[n] = r_d[n] + RW'(m_q[n][c]);
      end
      sep_d[n] = !skip_q[n] && (RW'(ad_q[n]) > r_d[n]);
    end
  end

  logic          v4_q;
  logic [NA-1:0] sep_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sep_q <= sep_d;
    end
  end

  logic overlap_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      overlap_q <= ~|sep_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v1_q      <= !q_empty_i;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      out_vld_q <= v4_q;
    end
  end

  assign empty_o   = !out_vld_q;
  assign overlap_o = overlap_q;

endmodule
`default_nettype wire

@@ design/obb_overlap_separating_axis.sv @@
`default_nettype none
// Oriented-box pair overlap by separating axes. One request (a box pair) is taken per clock
// while full is low, and one result comes out per request, in order. The front builds both
// bases from a sine table and the centre difference in registered stages; requests then pass
// an 8-entry queue to the back, which tests all 15 axes in parallel in a register pipeline
// whose last register holds the result. The front never stops: full rises when 8 requests
// sit in the front pipeline and queue together, so a held result stalls only the back. The
// threshold register may be written only while idle.
module obb_overlap_separating_axis #(
  parameter int unsigned CompBits    = obb_pkg::ComponentBitsDef,
  parameter int unsigned SineEntries = obb_pkg::SineEntriesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [obb_pkg::ThrBits-1:0]     cfg_wdata_i,
  input  logic                            push,
  output logic                            full,
  input  logic [obb_pkg::FieldBits-1:0]   first_position_i,
  input  logic [obb_pkg::FieldBits-1:0]   first_offset_i,
  input  logic [obb_pkg::FieldBits-1:0]   first_angles_i,
  input  logic [obb_pkg::FieldBits-1:0]   first_half_size_i,
  input  logic [obb_pkg::FieldBits-1:0]   second_position_i,
  input  logic [obb_pkg::FieldBits-1:0]   second_offset_i,
  input  logic [obb_pkg::FieldBits-1:0]   second_angles_i,
  input  logic [obb_pkg::FieldBits-1:0]   second_half_size_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            boxes_overlap_o
);

  localparam int unsigned BW      = obb_pkg::BasisBits;
  localparam int unsigned DW      = CompBits + 2;
  localparam int unsigned QW      = 18 * BW + 3 * DW + 6 * CompBits;
  localparam int unsigned QD      = obb_pkg::QueueDepth;
  localparam int unsigned CntBits = $clog2(QD + 1);

  logic [obb_pkg::ThrBits-1:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= obb_pkg::ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  logic accept;
  logic q_pop;
  logic [CntBits-1:0] credit_q;

  assign accept = push && !full;
  assign full   = (credit_q == CntBits'(QD));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_q + CntBits'(accept) - CntBits'(q_pop);
    end
  end

  logic                  f_vld;
  logic [9*BW-1:0]       f_ba, f_bb;
  logic [3*DW-1:0]       f_diff;
  logic [3*CompBits-1:0] f_ha, f_hb;

  obb_front #(.CompBits(CompBits), .SineEntries(SineEntries)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (accept),
    .first_position_i  (first_position_i),
    .first_offset_i    (first_offset_i),
    .first_angles_i    (first_angles_i),
    .first_half_size_i (first_half_size_i),
    .second_position_i (second_position_i),
    .second_offset_i   (second_offset_i),
    .second_angles_i   (second_angles_i),
    .second_half_size_i(second_half_size_i),
    .valid_o           (f_vld),
    .basis_a_o         (f_ba),
    .basis_b_o         (f_bb),
    .diff_o            (f_diff),
    .half_a_o          (f_ha),
    .half_b_o          (f_hb)
  );

  logic [QW-1:0]         q_data;
  logic                  q_empty;
  logic [9*BW-1:0]       b_ba, b_bb;
  logic [3*DW-1:0]       b_diff;
  logic [3*CompBits-1:0] b_ha, b_hb;

  obb_queue #(.Width(QW), .Depth(QD)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_vld),
    .data_i ({f_ba, f_bb, f_diff, f_ha, f_hb}),
    .pop_i  (q_pop),
    .data_o (q_data),
    .empty_o(q_empty)
  );

  assign {b_ba, b_bb, b_diff, b_ha, b_hb} = q_data;

  obb_back #(.CompBits(CompBits)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .thr_i    (thr_q),
    .q_empty_i(q_empty),
    .basis_a_i(b_ba),
    .basis_b_i(b_bb),
    .diff_i   (b_diff),
    .half_a_i (b_ha),
    .half_b_i (b_hb),
    .q_pop_o  (q_pop),
    .pop_i    (pop),
    .empty_o  (empty),
    .overlap_o(boxes_overlap_o)
  );

endmodule
`default_nettype wire
